/* hdl/ipval_pkg.sv */
package ipval_pkg;

  // Verdict codes carried on the result word.
  typedef logic [1:0] verdict_t;
  localparam verdict_t VERDICT_NONE = 2'd0;
  localparam verdict_t VERDICT_IPV4 = 2'd1;
  localparam verdict_t VERDICT_IPV6 = 2'd2;

  // Character codes of interest.
  localparam logic [7:0] CHAR_DOT    = 8'h2E;
  localparam logic [7:0] CHAR_COLON  = 8'h3A;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = 8'h39;
  localparam logic [7:0] CHAR_LOW_A  = 8'h61;
  localparam logic [7:0] CHAR_LOW_F  = 8'h66;
  localparam logic [7:0] CASE_BIT    = 8'h20;

  // Counter widths and limits.
  localparam int unsigned LEN_W     = 6;
  localparam int unsigned V4_SEG_W  = 3;
  localparam int unsigned V4_VAL_W  = 9;
  localparam int unsigned V6_SEG_W  = 4;
  localparam logic [LEN_W-1:0]    LEN_SAT       = 6'd63;
  localparam logic [V4_SEG_W-1:0] V4_SEG_SAT    = 3'd7;
  localparam logic [V6_SEG_W-1:0] V6_SEG_SAT    = 4'd15;
  localparam logic [V4_VAL_W-1:0] V4_VAL_SAT    = 9'd256;
  localparam logic [V4_VAL_W-1:0] V4_VAL_MAX    = 9'd255;
  localparam logic [V4_SEG_W-1:0] V4_SEG_COUNT  = 3'd4;
  localparam logic [V6_SEG_W-1:0] V6_SEG_COUNT  = 4'd8;
  localparam logic [LEN_W-1:0]    V6_DIGITS_MAX = 6'd4;

  // Classification of one character.
  typedef struct packed {
    logic       is_dot;
    logic       is_colon;
    logic       is_dec;
    logic       is_hex;
    logic       is_zero;
    logic [3:0] digit;
  } char_class_t;

endpackage

/* hdl/ipval_char_class.sv */
module ipval_char_class
  import ipval_pkg::*;
(
  input  logic [7:0]  char_code,
  output char_class_t cls
);

  logic [7:0] lower_code;

  // Folding the case bit maps upper-case letters onto lower-case ones.
  assign lower_code = char_code | CASE_BIT;

  // Decode separators and digit ranges.
  always_comb begin
    cls.is_dot   = (char_code == CHAR_DOT);
    cls.is_colon = (char_code == CHAR_COLON);
    cls.is_dec   = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
    cls.is_hex   = cls.is_dec ||
                   ((lower_code >= CHAR_LOW_A) && (lower_code <= CHAR_LOW_F));
    cls.is_zero  = (char_code == CHAR_ZERO);
    cls.digit    = char_code[3:0];
  end

endmodule

/* hdl/ip_address_text_validator_unit.sv */
// Address text validator: takes one character per word on the input channel
// and, on the word marked last, returns one verdict word (0 neither, 1 IPv4,
// 2 IPv6). Words without a character (no_char) only end a string when marked
// last. Every input word is absorbed as it is accepted, so a new word can be taken
// each clock; the verdict sits in an output register, and input is stalled
// only while that register is full and not being drained. The verdict appears in
// the cycle after the last word is taken. Strings longer than MAX_LENGTH
// characters are judged neither.
module ip_address_text_validator_unit
  import ipval_pkg::*;
#(
  parameter int MAX_LENGTH = 39
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char_code,
  input  logic       in_no_char,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_verdict
);

  localparam logic [LEN_W-1:0] MaxLen = LEN_W'(MAX_LENGTH);

  // Scan state.
  logic [LEN_W-1:0]    length_count_r, length_count_nxt;
  logic                dot_seen_r, dot_seen_nxt;
  logic                colon_seen_r, colon_seen_nxt;
  logic                v4_ok_r, v4_ok_nxt;
  logic [V4_SEG_W-1:0] v4_segments_r, v4_segments_nxt;
  logic [LEN_W-1:0]    v4_seg_length_r, v4_seg_length_nxt;
  logic [V4_VAL_W-1:0] v4_seg_value_r, v4_seg_value_nxt;
  logic                v4_leading_zero_r, v4_leading_zero_nxt;
  logic                v6_ok_r, v6_ok_nxt;
  logic [V6_SEG_W-1:0] v6_segments_r, v6_segments_nxt;
  logic [LEN_W-1:0]    v6_seg_length_r, v6_seg_length_nxt;

  // Output register.
  logic     out_valid_r, out_valid_nxt;
  verdict_t out_verdict_r, out_verdict_nxt;

  char_class_t cls;
  logic        accept;
  logic [11:0] value_times_ten;

  ipval_char_class u_char_class (
    .char_code (in_char_code),
    .cls       (cls)
  );

  assign in_ready    = !out_valid_r || out_ready;
  assign accept      = in_valid && in_ready;
  assign out_valid   = out_valid_r;
  assign out_verdict = out_verdict_r;

  // Decimal accumulate: value * 10 + digit, fits in 12 bits.
  assign value_times_ten = {v4_seg_value_r, 3'b000} + {2'b00, v4_seg_value_r, 1'b0}
                         + {8'd0, cls.digit};

  // Next scan state and verdict for the word at the input.
  always_comb begin
    length_count_nxt    = length_count_r;
    dot_seen_nxt        = dot_seen_r;
    colon_seen_nxt      = colon_seen_r;
    v4_ok_nxt           = v4_ok_r;
    v4_segments_nxt     = v4_segments_r;
    v4_seg_length_nxt   = v4_seg_length_r;
    v4_seg_value_nxt    = v4_seg_value_r;
    v4_leading_zero_nxt = v4_leading_zero_r;
    v6_ok_nxt           = v6_ok_r;
    v6_segments_nxt     = v6_segments_r;
    v6_seg_length_nxt   = v6_seg_length_r;
    out_verdict_nxt     = out_verdict_r;
    out_valid_nxt       = out_valid_r && !out_ready;

    if (accept) begin
      // Take the character, if any.
      if (!in_no_char) begin
        if (length_count_r >= MaxLen) begin
          v4_ok_nxt = 1'b0;
          v6_ok_nxt = 1'b0;
        end
        if (length_count_r != LEN_SAT) begin
          length_count_nxt = length_count_r + 1'b1;
        end
        if (cls.is_dot) begin
          dot_seen_nxt = 1'b1;
          v6_ok_nxt    = 1'b0;
          if ((v4_seg_length_r == '0) || (v4_leading_zero_r && v4_seg_length_r > 1) ||
              (v4_seg_value_r > V4_VAL_MAX)) begin
            v4_ok_nxt = 1'b0;
          end
          if (v4_segments_r != V4_SEG_SAT) begin
            v4_segments_nxt = v4_segments_r + 1'b1;
          end
          v4_seg_length_nxt   = '0;
          v4_seg_value_nxt    = '0;
          v4_leading_zero_nxt = 1'b0;
        end else if (cls.is_colon) begin
          colon_seen_nxt = 1'b1;
          v4_ok_nxt      = 1'b0;
          if ((v6_seg_length_r == '0) || (v6_seg_length_r > V6_DIGITS_MAX)) begin
            v6_ok_nxt = 1'b0;
          end
          if (v6_segments_r != V6_SEG_SAT) begin
            v6_segments_nxt = v6_segments_r + 1'b1;
          end
          v6_seg_length_nxt = '0;
        end else begin
          if (cls.is_dec) begin
            if ((v4_seg_length_r == '0) && cls.is_zero) begin
              v4_leading_zero_nxt = 1'b1;
            end
            if (value_times_ten > 12'(V4_VAL_SAT)) begin
              v4_seg_value_nxt = V4_VAL_SAT;
            end else begin
              v4_seg_value_nxt = value_times_ten[V4_VAL_W-1:0];
            end
            if (v4_seg_length_r != LEN_SAT) begin
              v4_seg_length_nxt = v4_seg_length_r + 1'b1;
            end
          end else begin
            v4_ok_nxt = 1'b0;
          end
          if (cls.is_hex) begin
            if (v6_seg_length_r != LEN_SAT) begin
              v6_seg_length_nxt = v6_seg_length_r + 1'b1;
            end
          end else begin
            v6_ok_nxt = 1'b0;
          end
        end
      end

      // End of string: close both open segments, judge, and start over.
      if (in_last) begin
        if ((v4_seg_length_nxt == '0) || (v4_leading_zero_nxt && v4_seg_length_nxt > 1) ||
            (v4_seg_value_nxt > V4_VAL_MAX)) begin
          v4_ok_nxt = 1'b0;
        end
        if (v4_segments_nxt != V4_SEG_SAT) begin
          v4_segments_nxt = v4_segments_nxt + 1'b1;
        end
        if ((v6_seg_length_nxt == '0) || (v6_seg_length_nxt > V6_DIGITS_MAX)) begin
          v6_ok_nxt = 1'b0;
        end
        if (v6_segments_nxt != V6_SEG_SAT) begin
          v6_segments_nxt = v6_segments_nxt + 1'b1;
        end

        out_verdict_nxt = VERDICT_NONE;
        if (length_count_nxt != '0) begin
          if (dot_seen_nxt) begin
            if (v4_ok_nxt && (v4_segments_nxt == V4_SEG_COUNT)) begin
              out_verdict_nxt = VERDICT_IPV4;
            end
          end else if (colon_seen_nxt) begin
            if (v6_ok_nxt && (v6_segments_nxt == V6_SEG_COUNT)) begin
              out_verdict_nxt = VERDICT_IPV6;
            end
          end
        end
        out_valid_nxt = 1'b1;

        length_count_nxt    = '0;
        dot_seen_nxt        = 1'b0;
        colon_seen_nxt      = 1'b0;
        v4_ok_nxt           = 1'b1;
        v4_segments_nxt     = '0;
        v4_seg_length_nxt   = '0;
        v4_seg_value_nxt    = '0;
        v4_leading_zero_nxt = 1'b0;
        v6_ok_nxt           = 1'b1;
        v6_segments_nxt     = '0;
        v6_seg_length_nxt   = '0;
      end
    end
  end

  // Scan state and output valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      length_count_r    <= '0;
      dot_seen_r        <= 1'b0;
      colon_seen_r      <= 1'b0;
      v4_ok_r           <= 1'b1;
      v4_segments_r     <= '0;
      v4_seg_length_r   <= '0;
      v4_seg_value_r    <= '0;
      v4_leading_zero_r <= 1'b0;
      v6_ok_r           <= 1'b1;
      v6_segments_r     <= '0;
      v6_seg_length_r   <= '0;
      out_valid_r       <= 1'b0;
    end else begin
      length_count_r    <= length_count_nxt;
      dot_seen_r        <= dot_seen_nxt;
      colon_seen_r      <= colon_seen_nxt;
      v4_ok_r           <= v4_ok_nxt;
      v4_segments_r     <= v4_segments_nxt;
      v4_seg_length_r   <= v4_seg_length_nxt;
      v4_seg_value_r    <= v4_seg_value_nxt;
      v4_leading_zero_r <= v4_leading_zero_nxt;
      v6_ok_r           <= v6_ok_nxt;
      v6_segments_r     <= v6_segments_nxt;
      v6_seg_length_r   <= v6_seg_length_nxt;
      out_valid_r       <= out_valid_nxt;
    end
  end

  // Verdict payload.
  always_ff @(posedge clk) begin
    out_verdict_r <= out_verdict_nxt;
  end

endmodule
